/* design/hrk512_pkg.sv */
`default_nettype none
package hrk512_pkg;

    localparam int NUM_ROUNDS = 5;
    localparam int NUM_HALVES = 80;
    localparam int NUM_STAGES = 2 * NUM_ROUNDS;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_PERM  = 2'd1;
    localparam logic [1:0] MODE_HASH  = 2'd2;

    typedef logic [63:0] word_t;
    typedef word_t [7:0] block_t;

    typedef struct packed {
        logic   hash;
        block_t orig;
    } side_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // 128-bit rc words listed most to least significant; low half = words 2,3
    function automatic logic [63:0] std_half(input logic [6:0] idx);
        logic [127:0] rc [40];
        logic [127:0] e;
        rc = '{
        128'h0684704ce620c00ab2c5fef075817b9d, 128'h8b66b4e188f3a06b640f6ba42f08f717,
        128'h3402de2d53f28498cf029d609f029114, 128'h0ed6eae62e7b4f08bbf3bcaffd5b4f79,
        128'hcbcfb0cb4872448b79eecd1cbe397044, 128'h7eeacdee6e9032b78d5335ed2b8a057b,
        128'h67c28f435e2e7cd0e2412761da4fef1b, 128'h2924d9b0afcacc07675ffde21fc70b3b,
        128'hab4d63f1e6867fe9ecdb8fcab9d465ee, 128'h1c30bf84d4b7cd645b2a404fad037e33,
        128'hb2cc0bb9941723bf69028b2e8df69800, 128'hfa0478a6de6f55724aaa9ec85c9d2d8a,
        128'hdfb49f2b6b772a120efa4f2e29129fd4, 128'h1ea10344f449a23632d611aebb6a12ee,
        128'haf0449884b0500845f9600c99ca8eca6, 128'h21025ed89d199c4f78a2c7e327e593ec,
        128'hbf3aaaf8a759c9b7b9282ecd82d40173, 128'h6260700d6186b01737f2efd910307d6b,
        128'h5aca45c22130044381c29153f6fc9ac6, 128'h9223973c226b68bb2caf92e836d1943a,
        128'hd3bf9238225886eb6cbab958e51071b4, 128'hdb863ce5aef0c677933dfddd24e1128d,
        128'hbb606268ffeba09c83e48de3cb2212b1, 128'h734bd3dce2e4d19c2db91a4ec72bf77d,
        128'h43bb47c361301b434b1415c42cb3924e, 128'hdba775a8e707eff603b231dd16eb6899,
        128'h6df3614b3c7559778e5e23027eca472c, 128'hcda75a17d6de7d776d1be5b9b88617f9,
        128'hec6b43f06ba8e9aa9d6c069da946ee5d, 128'hcb1e6950f957332ba25311593bf327c1,
        128'h2cee0c7500da619ce4ed0353600ed0d9, 128'hf0b1a5a196e90cab80bbbabc63a4a350,
        128'hae3db1025e962988ab0dde30938dca39, 128'h17bb8f38d554a40b8814f3a82e75b442,
        128'h34bb8a5b5f427fd7aeb6b779360a16f6, 128'h26f65241cbe5543843ce5918ffbaafde,
        128'h4ce99a54b9f3026aa2ca9cf7839ec978, 128'hae51a51a1bdff7be40c06e2822901235,
        128'ha0c1613cba7ed22bc173bc0f48a659cf, 128'h756acc03022882884ad6bdfde9c59da1};
        e = rc[idx[6:1]];
        return idx[0] ? e[127:64] : e[63:0];
    endfunction

    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k);
        logic [7:0] a [16];
        logic [7:0] b [16];
        logic [7:0] t;
        logic [127:0] o;
        for (int i = 0; i < 16; i++) a[i] = s[8*i +: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                b[r + 4*c] = sbox(a[r + 4*((c + r) % 4)]);
        for (int c = 0; c < 4; c++) begin
            t = b[4*c] ^ b[4*c+1] ^ b[4*c+2] ^ b[4*c+3];
            for (int r = 0; r < 4; r++)
                o[8*(4*c+r) +: 8] = b[4*c+r] ^ t ^ xtime(b[4*c+r] ^ b[4*c+((r+1)%4)]);
        end
        return o ^ k;
    endfunction

    function automatic block_t mix(input block_t w);
        logic [31:0] s [16];
        logic [31:0] t [16];
        block_t o;
        for (int j = 0; j < 8; j++) begin
            s[2*j] = w[j][31:0];
            s[2*j+1] = w[j][63:32];
        end
        t[12] = s[2];  t[13] = s[10]; t[14] = s[6];  t[15] = s[14];
        t[0]  = s[3];  t[1]  = s[11]; t[2]  = s[7];  t[3]  = s[15];
        t[8]  = s[9];  t[9]  = s[1];  t[10] = s[13]; t[11] = s[5];
        t[4]  = s[8];  t[5]  = s[0];  t[6]  = s[12]; t[7]  = s[4];
        for (int j = 0; j < 8; j++) o[j] = {t[2*j+1], t[2*j]};
        return o;
    endfunction

endpackage
`default_nettype wire

/* design/hrk512_stage.sv */
`default_nettype none
module hrk512_stage #(
    parameter int STEP = 0
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  en,
    input  wire                  in_valid,
    input  hrk512_pkg::block_t   in_block,
    input  hrk512_pkg::side_t    in_side,
    input  wire  [63:0]          rc_lo [4],
    input  wire  [63:0]          rc_hi [4],
    output logic                 out_valid,
    output hrk512_pkg::block_t   out_block,
    output hrk512_pkg::side_t    out_side
);
    hrk512_pkg::block_t blk_next;
    hrk512_pkg::block_t aes_out;
    logic               valid_reg;
    hrk512_pkg::block_t block_reg;
    hrk512_pkg::side_t  side_reg;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            {aes_out[2*l+1], aes_out[2*l]} = hrk512_pkg::aes_round(
                {in_block[2*l+1], in_block[2*l]}, {rc_hi[l], rc_lo[l]});
        end
        blk_next = (STEP % 2 == 1) ? hrk512_pkg::mix(aes_out) : aes_out;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            block_reg <= blk_next;
            side_reg  <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_block = block_reg;
    assign out_side  = side_reg;
endmodule
`default_nettype wire

/* design/haraka512_permutation_hash.sv */
`default_nettype none
// channel   ports        tdata fields (low to high)
// s_axis    s_tvalid/... mode[1:0], constant_index[8:2], in_word0..7 [520:9], pad to 528
// m_axis    m_tvalid/... out_word0..7 [511:0]
// Ten register stages, one AES round per stage (mix after every second);
// one block enters per cycle unless m_tready stalls; an output register follows.
// Reset restores the standard round constants; a constant write waits until
// no block is left in the stages that read constants, then takes effect.
// A stall on m_tready freezes the whole pipeline; nothing is lost or repeated.
module haraka512_permutation_hash (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [527:0] s_tdata,   // mode, constant_index, in_word0..in_word7
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [511:0] m_tdata    // out_word0..out_word7
);
    localparam int NS = hrk512_pkg::NUM_STAGES;

    logic [1:0]  mode;
    logic [6:0]  cidx;
    hrk512_pkg::block_t in_blk;
    logic [63:0] rc_reg [hrk512_pkg::NUM_HALVES];
    logic [hrk512_pkg::NUM_HALVES-1:0] written_reg;
    logic        en;
    logic        busy;
    logic        s_fire;
    logic        v   [NS+1];
    hrk512_pkg::block_t b [NS+1];
    hrk512_pkg::side_t  sd [NS+1];
    logic        out_valid_reg;
    logic [511:0] out_data_reg;
    logic [511:0] out_data_next;

    assign mode = s_tdata[1:0];
    assign cidx = s_tdata[8:2];
    always_comb begin
        for (int j = 0; j < 8; j++) in_blk[j] = s_tdata[9 + 64*j +: 64];
    end

    // blocks still ahead of a constant-reading stage
    always_comb begin
        busy = 1'b0;
        for (int k = 1; k < NS; k++) busy = busy | v[k];
    end

    assign en       = !out_valid_reg || m_tready;
    // hold a constant write until the blocks in flight have used the old values
    assign s_tready = en && !(mode == hrk512_pkg::MODE_WRITE && busy);
    assign s_fire   = s_tvalid && s_tready;

    // constants reset via valid bits; unwritten entries read the standard value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (s_fire && mode == hrk512_pkg::MODE_WRITE &&
                     cidx < 7'(hrk512_pkg::NUM_HALVES)) begin
            written_reg[cidx] <= 1'b1;
        end
        if (s_fire && mode == hrk512_pkg::MODE_WRITE &&
            cidx < 7'(hrk512_pkg::NUM_HALVES)) begin
            rc_reg[cidx] <= in_blk[0];
        end
    end

    assign v[0]  = s_fire && (mode == hrk512_pkg::MODE_PERM || mode == hrk512_pkg::MODE_HASH);
    assign b[0]  = in_blk;
    assign sd[0] = '{hash: (mode == hrk512_pkg::MODE_HASH), orig: in_blk};

    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_stage
            logic [63:0] lo [4];
            logic [63:0] hi [4];
            for (genvar l = 0; l < 4; l++) begin : g_lane
                localparam int E = 4*g + l;
                assign lo[l] = written_reg[2*E]   ? rc_reg[2*E]
                                                  : hrk512_pkg::std_half(7'(2*E));
                assign hi[l] = written_reg[2*E+1] ? rc_reg[2*E+1]
                                                  : hrk512_pkg::std_half(7'(2*E+1));
            end
            hrk512_stage #(.STEP(g)) u_stage (
                .aclk(aclk), .aresetn(aresetn), .en(en),
                .in_valid(v[g]), .in_block(b[g]), .in_side(sd[g]),
                .rc_lo(lo), .rc_hi(hi),
                .out_valid(v[g+1]), .out_block(b[g+1]), .out_side(sd[g+1])
            );
        end
    endgenerate

    always_comb begin
        if (sd[NS].hash) begin
            out_data_next = {256'd0,
                             b[NS][6] ^ sd[NS].orig[6], b[NS][4] ^ sd[NS].orig[4],
                             b[NS][3] ^ sd[NS].orig[3], b[NS][1] ^ sd[NS].orig[1]};
        end else begin
            out_data_next = b[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v[NS];
        end
        if (en) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == ((!m_tvalid || m_tready) &&
                     !(s_tdata[1:0] == hrk512_pkg::MODE_WRITE && busy)))
        else $error("ready mismatch");
    a_hash_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        en && v[NS] && sd[NS].hash |=> m_tdata[511:256] == 256'd0)
        else $error("hash upper words not zero");
`endif
endmodule
`default_nettype wire
